FILE: rtl/core/rmi_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Regret matching information set unit: shared definitions
// Command codes, register indexes, datapath widths and the request and
// response words of the shared divider.
// ---------------------------------------------------------------------------
package rmi_pkg;

  // A sum over up to 64 entries of 32 bits needs 38 bits.
  localparam int SUM_W  = 38;
  localparam int QUOT_W = 17;
  localparam int WORD_W = 32;

  localparam logic [2:0] CMD_SET_INSTANT   = 3'd0;
  localparam logic [2:0] CMD_ACC_REGRET    = 3'd1;
  localparam logic [2:0] CMD_ACC_STRATEGY  = 3'd2;
  localparam logic [2:0] CMD_READ_CURRENT  = 3'd3;
  localparam logic [2:0] CMD_READ_AVERAGE  = 3'd4;
  localparam logic [2:0] CMD_READ_REGRET   = 3'd5;

  localparam logic [1:0] REG_ACTION_COUNT = 2'd0;
  localparam logic [1:0] REG_EPSILON      = 2'd1;

  // One in Q1.16.
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Divider request: the dividend is {hi, lo}, the quotient has QUOT_W bits.
  typedef struct packed {
    logic               start;
    logic [WORD_W-1:0]  hi;
    logic [15:0]        lo;
    logic [SUM_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/core/rmi_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Regret matching information set unit: shared divider
// Restoring divider, one quotient bit per cycle, 17 quotient bits. The upper
// dividend part must be below twice the divisor.
// ---------------------------------------------------------------------------
module rmi_div (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rmi_pkg::div_req_t req,
  output rmi_pkg::div_rsp_t     rsp
);

  localparam int SW = rmi_pkg::SUM_W;
  localparam int QW = rmi_pkg::QUOT_W;
  localparam logic [4:0] LAST_STEP = 5'(QW - 1);

  logic [SW:0]   rem;
  logic [15:0]   low;
  logic [SW-1:0] divisor;
  logic [QW-1:0] quot;
  logic [4:0]    cnt;
  logic          run;
  logic          done;
  logic          ge;
  logic [SW:0]   diff;
  logic [SW-1:0] rem_keep;

  assign diff     = rem - {1'b0, divisor};
  assign ge       = (rem >= {1'b0, divisor});
  assign rem_keep = ge ? diff[SW-1:0] : rem[SW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 5'd1;
        if (cnt == LAST_STEP) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= (SW + 1)'(req.hi);
      low     <= req.lo;
      divisor <= req.divisor;
    end else if (run) begin
      rem  <= {rem_keep, low[15]};
      low  <= {low[14:0], 1'b0};
      quot <= {quot[QW-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule
`default_nettype wire

FILE: rtl/core/rmi_mul.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Regret matching information set unit: shared multiplier
// Unsigned 32 by 32 multiplier with a registered 64-bit product.
// ---------------------------------------------------------------------------
module rmi_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= {32'b0, a} * {32'b0, b};
  end

endmodule
`default_nettype wire

FILE: rtl/core/regret_matching_infoset_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Regret matching information set unit
// Keeps instant regrets, regret sums, a cached strategy and strategy sums for
// one information set, and answers commands that update or read them.
// ---------------------------------------------------------------------------
//
//   channel   ports                                        handshake
//   -------   ------------------------------------------   -------------------
//   command   start, busy, command, action_index,          start && !busy
//             regret_in, weight
//   result    strobe, out_action, probability,             strobe, one cycle
//             regret_out, last
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data    cfg_valid && cfg_ready
//
// Setting an instant regret is written at the accepting edge and never
// raises busy. Reading the regret sums and accumulating regret make one
// pass over the actions; the shared 17-step divider paces normalizing
// (one division per action, or one for 1/n when the sum is zero) and the
// epsilon over n of the softened current strategy. Reset clears the
// sequencer state and marks every instant regret, regret sum and strategy
// sum entry as zero at once. The receiver of results cannot stall; each
// result word is on the ports for exactly one cycle. Register writes are
// taken only while the unit is idle and no command word is offered.
// ---------------------------------------------------------------------------
module regret_matching_infoset_unit #(
  parameter int MAX_ACTIONS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  command,
  input  wire logic [5:0]  action_index,
  input  wire logic signed [31:0] regret_in,
  input  wire logic [31:0] weight,
  // result channel
  output logic             strobe,
  output logic      [5:0]  out_action,
  output logic      [16:0] probability,
  output logic      [30:0] regret_out,
  output logic             last,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int IW = $clog2(MAX_ACTIONS);
  localparam int NW = $clog2(MAX_ACTIONS + 1);
  localparam int SW = rmi_pkg::SUM_W;

  // Sequencer states.
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_SUM_RD   = 5'd1;
  localparam logic [4:0] S_SUM_ACC  = 5'd2;
  localparam logic [4:0] S_NRM_CHK  = 5'd3;
  localparam logic [4:0] S_UNI_WAIT = 5'd4;
  localparam logic [4:0] S_NRM_RD   = 5'd5;
  localparam logic [4:0] S_NRM_DIV  = 5'd6;
  localparam logic [4:0] S_NRM_WAIT = 5'd7;
  localparam logic [4:0] S_NRM_PUT  = 5'd8;
  localparam logic [4:0] S_EPS      = 5'd9;
  localparam logic [4:0] S_EPS_WAIT = 5'd10;
  localparam logic [4:0] S_CUR_RD   = 5'd11;
  localparam logic [4:0] S_CUR_MUL  = 5'd12;
  localparam logic [4:0] S_CUR_SOFT = 5'd13;
  localparam logic [4:0] S_CUR_ACC  = 5'd14;
  localparam logic [4:0] S_ACC_RD   = 5'd15;
  localparam logic [4:0] S_ACC_MUL  = 5'd16;
  localparam logic [4:0] S_ACC_ADD  = 5'd17;
  localparam logic [4:0] S_RS_RD    = 5'd18;
  localparam logic [4:0] S_RS_OUT   = 5'd19;

  // Control and configuration registers.
  logic [4:0]    state;
  logic [IW-1:0] idx;
  logic [2:0]    cmd_q;
  logic [31:0]   w_q;
  logic [SW-1:0] sum;
  logic          uni;
  logic          cache_valid;
  logic [6:0]    action_count;
  logic [15:0]   epsilon;

  // Storage. All arrays are read at the loop index with a registered read.
  logic [31:0] inst_mem  [MAX_ACTIONS];
  logic [30:0] rsum_mem  [MAX_ACTIONS];
  logic [16:0] cache_mem [MAX_ACTIONS];
  logic [31:0] ssum_mem  [MAX_ACTIONS];

  // Per-entry valid flags stand in for the zero reset of three of the stores.
  logic [MAX_ACTIONS-1:0] inst_vld;
  logic [MAX_ACTIONS-1:0] rsum_vld;
  logic [MAX_ACTIONS-1:0] ssum_vld;

  logic [31:0] rd_inst;
  logic [30:0] rd_rsum;
  logic [16:0] rd_cache;
  logic [31:0] rd_ssum;
  logic        rd_inst_v;
  logic        rd_rsum_v;
  logic        rd_ssum_v;

  logic [31:0] inst_e;
  logic [30:0] rsum_e;
  logic [31:0] ssum_e;

  logic          accept;
  logic [6:0]    n_full;
  logic [NW-1:0] n_act;
  logic [NW-1:0] n_m1;
  logic          idx_last;
  logic          avg;
  logic [31:0]   v_eff;

  logic        inst_we;
  logic [IW-1:0] inst_waddr;
  logic        rsum_we;
  logic [30:0] rsum_wd;
  logic        cache_we;
  logic        ssum_we;
  logic [31:0] ssum_wd;

  rmi_pkg::div_req_t div_req;
  rmi_pkg::div_rsp_t div_rsp;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  logic [31:0] inst_mag;
  logic [16:0] p_cur;
  logic [64:0] mag_adj;
  logic [48:0] scaled;
  logic [50:0] rsum_t;
  logic [48:0] ssum_t;

  assign busy      = (state != S_IDLE);
  // A register write never lands on the edge that takes a command word, so
  // every command sees one settled set of registers.
  assign cfg_ready = ~busy & ~start;
  assign accept    = start & ~busy;

  // Active action count: zero acts as one, anything above the built maximum
  // acts as the maximum.
  always_comb begin
    if (action_count == 7'd0) begin
      n_full = 7'd1;
    end else if (action_count > 7'(MAX_ACTIONS)) begin
      n_full = 7'(MAX_ACTIONS);
    end else begin
      n_full = action_count;
    end
  end

  assign n_act    = n_full[NW-1:0];
  assign n_m1     = n_act - NW'(1);
  assign idx_last = (NW'(idx) == n_m1);
  assign avg      = (cmd_q == rmi_pkg::CMD_READ_AVERAGE);

  // Entries never written read as zero.
  assign inst_e = rd_inst_v ? rd_inst : 32'd0;
  assign rsum_e = rd_rsum_v ? rd_rsum : 31'd0;
  assign ssum_e = rd_ssum_v ? rd_ssum : 32'd0;

  // Normalizing walks the strategy sums for the average strategy and the
  // regret sums otherwise.
  assign v_eff = avg ? ssum_e : {1'b0, rsum_e};

  // ---- memories ----------------------------------------------------------
  assign inst_we    = accept && (command == rmi_pkg::CMD_SET_INSTANT) &&
                      ({1'b0, action_index} < 7'(MAX_ACTIONS));
  assign inst_waddr = action_index[IW-1:0];
  assign rsum_we    = (state == S_ACC_ADD);
  assign cache_we   = (state == S_NRM_PUT) && !avg;
  assign ssum_we    = (state == S_CUR_ACC);

  always_ff @(posedge clk) begin
    if (inst_we) begin
      inst_mem[inst_waddr] <= regret_in;
    end
    if (rsum_we) begin
      rsum_mem[idx] <= rsum_wd;
    end
    if (cache_we) begin
      cache_mem[idx] <= div_rsp.quot;
    end
    if (ssum_we) begin
      ssum_mem[idx] <= ssum_wd;
    end
    rd_inst  <= inst_mem[idx];
    rd_rsum  <= rsum_mem[idx];
    rd_cache <= cache_mem[idx];
    rd_ssum  <= ssum_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inst_vld  <= '0;
      rsum_vld  <= '0;
      ssum_vld  <= '0;
      rd_inst_v <= 1'b0;
      rd_rsum_v <= 1'b0;
      rd_ssum_v <= 1'b0;
    end else begin
      if (inst_we) begin
        inst_vld[inst_waddr] <= 1'b1;
      end
      if (rsum_we) begin
        rsum_vld[idx] <= 1'b1;
      end
      if (ssum_we) begin
        ssum_vld[idx] <= 1'b1;
      end
      rd_inst_v <= inst_vld[idx];
      rd_rsum_v <= rsum_vld[idx];
      rd_ssum_v <= ssum_vld[idx];
    end
  end

  // ---- shared divider ----------------------------------------------------
  // Three uses: v * 2^16 / sum, 2^16 / n for the uniform case, and
  // epsilon / n for softening. The quotient holds until the next start, so
  // the loops read it straight from the divider.
  always_comb begin
    div_req.start   = 1'b0;
    div_req.hi      = v_eff;
    div_req.lo      = 16'd0;
    div_req.divisor = sum;
    unique case (state)
      S_NRM_CHK: begin
        div_req.start   = (sum == '0);
        div_req.hi      = 32'd1;
        div_req.divisor = SW'(n_act);
      end
      S_NRM_DIV: begin
        div_req.start = !uni;
      end
      S_EPS: begin
        div_req.start   = (epsilon != 16'd0);
        div_req.hi      = 32'd0;
        div_req.lo      = epsilon;
        div_req.divisor = SW'(n_act);
      end
      default: begin
      end
    endcase
  end

  rmi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---- shared multiplier -------------------------------------------------
  assign inst_mag = inst_e[31] ? (~inst_e + 32'd1) : inst_e;

  // Softened probability: epsilon / n plus (1 - epsilon) times the cached
  // value, or the cached value alone when softening is off.
  assign p_cur = (epsilon != 16'd0) ? (div_rsp.quot + prod[32:16]) : rd_cache;

  always_comb begin
    unique case (state)
      S_CUR_MUL: begin
        mul_a = 32'(rmi_pkg::ONE_Q16 - {1'b0, epsilon});
        mul_b = 32'(rd_cache);
      end
      S_CUR_SOFT: begin
        mul_a = w_q;
        mul_b = 32'(p_cur);
      end
      default: begin
        mul_a = w_q;
        mul_b = inst_mag;
      end
    endcase
  end

  rmi_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Regret update. A negative instant regret scales with rounding toward
  // minus infinity, so its magnitude rounds up before the shift.
  assign mag_adj = {1'b0, prod} + 65'(16'hFFFF);
  assign scaled  = inst_e[31] ? mag_adj[64:16] : {1'b0, prod[63:16]};
  assign rsum_t  = inst_e[31] ? (51'(rsum_e) - 51'(scaled)) : (51'(rsum_e) + 51'(scaled));

  always_comb begin
    if (rsum_t[50]) begin
      rsum_wd = 31'd0;
    end else if (rsum_t[49:31] != '0) begin
      rsum_wd = 31'h7FFF_FFFF;
    end else begin
      rsum_wd = rsum_t[30:0];
    end
  end

  // Strategy update saturates at the top of 32 bits.
  assign ssum_t  = 49'(ssum_e) + 49'(prod[63:16]);
  assign ssum_wd = (ssum_t[48:32] != '0) ? 32'hFFFF_FFFF : ssum_t[31:0];

  // ---- sequencer ---------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      cmd_q        <= rmi_pkg::CMD_SET_INSTANT;
      uni          <= 1'b0;
      cache_valid  <= 1'b0;
      action_count <= 7'd8;
      epsilon      <= 16'd0;
      strobe       <= 1'b0;
    end else begin
      strobe <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          rmi_pkg::REG_ACTION_COUNT: begin
            action_count <= cfg_data[6:0];
            cache_valid  <= 1'b0;
          end
          rmi_pkg::REG_EPSILON: begin
            epsilon <= cfg_data;
          end
          default: begin
          end
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q <= command;
            w_q   <= weight;
            idx   <= '0;
            sum   <= '0;
            unique case (command)
              rmi_pkg::CMD_ACC_REGRET: begin
                state <= S_ACC_RD;
              end
              rmi_pkg::CMD_ACC_STRATEGY, rmi_pkg::CMD_READ_CURRENT: begin
                state <= cache_valid ? S_EPS : S_SUM_RD;
              end
              rmi_pkg::CMD_READ_AVERAGE: begin
                state <= S_SUM_RD;
              end
              rmi_pkg::CMD_READ_REGRET: begin
                state <= S_RS_RD;
              end
              default: begin
                // Setting an instant regret needs no sequencing; unknown
                // commands do nothing.
              end
            endcase
          end
        end

        // Sum of the entries to normalize.
        S_SUM_RD: begin
          state <= S_SUM_ACC;
        end
        S_SUM_ACC: begin
          sum <= sum + SW'(v_eff);
          if (idx_last) begin
            state <= S_NRM_CHK;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_SUM_RD;
          end
        end
        S_NRM_CHK: begin
          idx <= '0;
          uni <= (sum == '0);
          state <= (sum == '0) ? S_UNI_WAIT : S_NRM_RD;
        end
        S_UNI_WAIT: begin
          if (div_rsp.done) begin
            state <= S_NRM_RD;
          end
        end

        // One division per action, unless every entry gets 1/n.
        S_NRM_RD: begin
          state <= S_NRM_DIV;
        end
        S_NRM_DIV: begin
          state <= uni ? S_NRM_PUT : S_NRM_WAIT;
        end
        S_NRM_WAIT: begin
          if (div_rsp.done) begin
            state <= S_NRM_PUT;
          end
        end
        S_NRM_PUT: begin
          if (avg) begin
            strobe      <= 1'b1;
            out_action  <= 6'(idx);
            probability <= div_rsp.quot;
            regret_out  <= 31'd0;
            last        <= idx_last;
          end
          if (idx_last) begin
            if (avg) begin
              state <= S_IDLE;
            end else begin
              cache_valid <= 1'b1;
              state       <= S_EPS;
            end
          end else begin
            idx   <= idx + IW'(1);
            state <= S_NRM_RD;
          end
        end

        // Softened current strategy from the cache.
        S_EPS: begin
          idx   <= '0;
          state <= (epsilon != 16'd0) ? S_EPS_WAIT : S_CUR_RD;
        end
        S_EPS_WAIT: begin
          if (div_rsp.done) begin
            state <= S_CUR_RD;
          end
        end
        S_CUR_RD: begin
          state <= S_CUR_MUL;
        end
        S_CUR_MUL: begin
          state <= S_CUR_SOFT;
        end
        S_CUR_SOFT: begin
          if (cmd_q == rmi_pkg::CMD_READ_CURRENT) begin
            strobe      <= 1'b1;
            out_action  <= 6'(idx);
            probability <= p_cur;
            regret_out  <= 31'd0;
            last        <= idx_last;
            if (idx_last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + IW'(1);
              state <= S_CUR_RD;
            end
          end else begin
            state <= S_CUR_ACC;
          end
        end
        S_CUR_ACC: begin
          if (idx_last) begin
            state <= S_IDLE;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_CUR_RD;
          end
        end

        // Regret accumulation; the cache goes stale at the end.
        S_ACC_RD: begin
          state <= S_ACC_MUL;
        end
        S_ACC_MUL: begin
          state <= S_ACC_ADD;
        end
        S_ACC_ADD: begin
          if (idx_last) begin
            cache_valid <= 1'b0;
            state       <= S_IDLE;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_ACC_RD;
          end
        end

        // Regret sums read out.
        S_RS_RD: begin
          state <= S_RS_OUT;
        end
        S_RS_OUT: begin
          strobe      <= 1'b1;
          out_action  <= 6'(idx);
          probability <= 17'd0;
          regret_out  <= rsum_e;
          last        <= idx_last;
          if (idx_last) begin
            state <= S_IDLE;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_RS_RD;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---- assertions --------------------------------------------------------

  // The final word of a read run leaves the unit ready for the next command.
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("busy still high on the final result word");

  // Result words come only from the three read commands.
  a_strobe_cmd: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (cmd_q == rmi_pkg::CMD_READ_CURRENT ||
                cmd_q == rmi_pkg::CMD_READ_AVERAGE ||
                cmd_q == rmi_pkg::CMD_READ_REGRET))
    else $error("result word for a command that returns none");

  // The divider finishes only while the sequencer waits for it.
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_NRM_WAIT || state == S_UNI_WAIT ||
                      state == S_EPS_WAIT))
    else $error("divider finished outside a wait state");

  // The cache becomes valid only by finishing a normalizing pass into it.
  a_cache_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(cache_valid) |-> $past(state) == S_NRM_PUT)
    else $error("cache marked valid without being filled");

endmodule
`default_nettype wire

FILE: dv/regret_matching_infoset_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the regret matching information set unit
// Drives command words and register writes into the unit and checks every
// result word against a cycle-free model of the regret store that is kept
// inside a small scoreboard.
// ---------------------------------------------------------------------------
module regret_matching_infoset_unit_tb;

  localparam int ACTIONS = 8;

  // Command codes that the unit must ignore, and register indexes beyond the
  // two real registers. Writes to the spare indexes must change nothing.
  localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;
  localparam logic [1:0] REG_SPARE_LO  = 2'd2;
  localparam logic [1:0] REG_SPARE_HI  = 2'd3;

  // The slowest command is a strategy accumulation that has to rebuild the
  // cached strategy and soften it. DRAIN_CYCLES covers that with margin, and
  // it is the pause used before a register write and at the end, since
  // commands that return no word can still be running when the last expected
  // word has arrived. The watchdog limit is several times the longest quiet
  // stretch of a correct run.
  localparam int DRAIN_CYCLES    = 400;
  localparam int STALL_LIMIT     = 4000;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 45;

  typedef struct packed {
    logic [5:0]  action;
    logic [16:0] prob;
    logic [30:0] regret;
    logic        last_flag;
  } result_word_t;

  // -------------------------------------------------------------------------
  // Scoreboard. It keeps its own copy of the regret store and of the two
  // registers, turns each accepted command into the result words it must
  // produce, and compares every word that comes out with the oldest one
  // still waiting.
  // -------------------------------------------------------------------------
  class infoset_scoreboard;
    logic signed [31:0] instant [ACTIONS];
    logic [30:0]        regret_sum [ACTIONS];
    logic [16:0]        cached [ACTIONS];
    logic [31:0]        strategy_sum [ACTIONS];
    bit                 cache_fresh;
    logic [6:0]         count_reg;
    logic [15:0]        epsilon_reg;
    // Scratch: values to be normalized, and the resulting shares.
    logic [31:0]        norm_in [ACTIONS];
    logic [16:0]        share [ACTIONS];
    result_word_t       expected_words [$];
    int                 errors;
    int                 words_checked;
    int                 commands_seen;
    int                 settings_seen;

    function void clear();
      int i;
      for (i = 0; i < ACTIONS; i++) begin
        instant[i] = '0;
        regret_sum[i] = '0;
        cached[i] = '0;
        strategy_sum[i] = '0;
      end
      cache_fresh = 1'b0;
      count_reg = 7'd8;
      epsilon_reg = '0;
      expected_words.delete();
      errors = 0;
      words_checked = 0;
      commands_seen = 0;
      settings_seen = 1;
    endfunction

    function int outstanding();
      return expected_words.size();
    endfunction

    // A count of zero behaves as one, anything above the built size as the
    // built size.
    function int active_actions();
      if (count_reg == 0) return 1;
      if (count_reg > ACTIONS) return ACTIONS;
      return count_reg;
    endfunction

    // Shares of norm_in in Q1.16, rounded down; uniform when all are zero.
    function void normalize(int n);
      logic [63:0] total;
      int i;
      total = '0;
      for (i = 0; i < n; i++) total += norm_in[i];
      for (i = 0; i < n; i++) begin
        if (total != 0) share[i] = 17'(({32'd0, norm_in[i]} << 16) / total);
        else share[i] = 17'(65536 / n);
      end
    endfunction

    // Rebuilds the cached strategy from the regret sums when it is stale,
    // then softens it toward uniform by epsilon.
    function void current_strategy(int n);
      logic [33:0] part;
      int i;
      if (!cache_fresh) begin
        for (i = 0; i < n; i++) norm_in[i] = {1'b0, regret_sum[i]};
        normalize(n);
        for (i = 0; i < n; i++) cached[i] = share[i];
        cache_fresh = 1'b1;
      end
      for (i = 0; i < n; i++) begin
        if (epsilon_reg != 0) begin
          part = ((34'd65536 - epsilon_reg) * cached[i]) >> 16;
          share[i] = 17'(epsilon_reg / n + part);
        end else begin
          share[i] = cached[i];
        end
      end
    endfunction

    function void note_config(logic [1:0] index, logic [15:0] data);
      if (index == rmi_pkg::REG_ACTION_COUNT) begin
        count_reg = data[6:0];
        cache_fresh = 1'b0;
      end else if (index == rmi_pkg::REG_EPSILON) begin
        epsilon_reg = data;
      end
    endfunction

    function void note_command(logic [2:0] cmd, logic [5:0] idx,
                               logic signed [31:0] rin, logic [31:0] w);
      logic signed [64:0] prod;
      logic signed [65:0] acc;
      logic [63:0]        grown;
      result_word_t       word;
      int                 n;
      int                 i;
      n = active_actions();
      commands_seen++;
      case (cmd)
        rmi_pkg::CMD_SET_INSTANT: begin
          if (idx < ACTIONS) instant[idx] = rin;
        end
        rmi_pkg::CMD_ACC_REGRET: begin
          // The arithmetic shift rounds the scaled product toward minus
          // infinity, which is what the unit must do for negative regrets.
          for (i = 0; i < n; i++) begin
            prod = $signed({1'b0, w}) * instant[i];
            acc = $signed({35'd0, regret_sum[i]}) + (prod >>> 16);
            if (acc < 0) regret_sum[i] = '0;
            else if (acc > 66'sd2147483647) regret_sum[i] = 31'h7FFFFFFF;
            else regret_sum[i] = acc[30:0];
          end
          cache_fresh = 1'b0;
        end
        rmi_pkg::CMD_ACC_STRATEGY: begin
          current_strategy(n);
          for (i = 0; i < n; i++) begin
            grown = {32'd0, strategy_sum[i]} + (({32'd0, w} * share[i]) >> 16);
            strategy_sum[i] = (grown > 64'hFFFFFFFF) ? 32'hFFFFFFFF : grown[31:0];
          end
        end
        rmi_pkg::CMD_READ_CURRENT, rmi_pkg::CMD_READ_AVERAGE,
        rmi_pkg::CMD_READ_REGRET: begin
          if (cmd == rmi_pkg::CMD_READ_CURRENT) begin
            current_strategy(n);
          end else if (cmd == rmi_pkg::CMD_READ_AVERAGE) begin
            for (i = 0; i < n; i++) norm_in[i] = strategy_sum[i];
            normalize(n);
          end
          for (i = 0; i < n; i++) begin
            word.action = 6'(i);
            word.prob = (cmd == rmi_pkg::CMD_READ_REGRET) ? '0 : share[i];
            word.regret = (cmd == rmi_pkg::CMD_READ_REGRET) ? regret_sum[i] : '0;
            word.last_flag = (i == n - 1);
            expected_words.insert(expected_words.size(), word);
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(logic [5:0] action, logic [16:0] prob,
                               logic [30:0] regret, logic last_flag);
      result_word_t want;
      words_checked++;
      if (expected_words.size() == 0) begin
        $error("result word for action %0d arrived with nothing expected", action);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      if (action !== want.action) begin
        $error("out_action: expected %0d, got %0d", want.action, action);
        errors++;
      end
      if (prob !== want.prob) begin
        $error("probability: expected %0d, got %0d", want.prob, prob);
        errors++;
      end
      if (regret !== want.regret) begin
        $error("regret_out: expected %0d, got %0d", want.regret, regret);
        errors++;
      end
      if (last_flag !== want.last_flag) begin
        $error("last: expected %0d, got %0d", want.last_flag, last_flag);
        errors++;
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // Clock, reset and the ports of the unit. Every input has a known value
  // from time zero.
  // -------------------------------------------------------------------------
  logic               clk;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         command = rmi_pkg::CMD_SET_INSTANT;
  logic [5:0]         action_index = '0;
  logic signed [31:0] regret_in = '0;
  logic [31:0]        weight = '0;
  logic               strobe;
  logic [5:0]         out_action;
  logic [16:0]        probability;
  logic [30:0]        regret_out;
  logic               last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = rmi_pkg::REG_ACTION_COUNT;
  logic [15:0]        cfg_data = '0;

  infoset_scoreboard  sb;
  int                 idle_cycles = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  regret_matching_infoset_unit #(
    .MAX_ACTIONS (ACTIONS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .action_index (action_index),
    .regret_in    (regret_in),
    .weight       (weight),
    .strobe       (strobe),
    .out_action   (out_action),
    .probability  (probability),
    .regret_out   (regret_out),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Result words cannot be held off, so every edge with the strobe high
  // takes one word. Outputs are read right after the edge, before any
  // register of the unit has taken its new value.
  always @(posedge clk) begin
    if (!rst && strobe) sb.check_result(out_action, probability, regret_out, last);
  end

  // The watchdog counts edges at which no word moves on any channel. A
  // correct run never stays quiet longer than a drain pause.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Drivers. A command word is presented after its gap and held until the
  // edge that sees start high and busy low. start is left high on return so
  // that a following word with no gap goes out without a dip; the next call
  // or settle() lowers it, so start gets one update per time step at most.
  // -------------------------------------------------------------------------
  task automatic send_command(input logic [2:0] cmd, input logic [5:0] idx,
                              input logic [31:0] rin, input logic [31:0] w,
                              input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    command      <= cmd;
    action_index <= idx;
    regret_in    <= rin;
    weight       <= w;
    do @(posedge clk); while (busy);
    sb.note_command(cmd, idx, rin, w);
  endtask

  // cfg_valid stays high across back-to-back writes; set_registers() drops
  // it once the whole batch is in.
  task automatic write_register(input logic [1:0] index, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(index, data);
  endtask

  task automatic set_registers(input logic [15:0] count_data,
                               input logic [15:0] eps_data, input bit touch_spare);
    if (touch_spare) begin
      write_register(REG_SPARE_LO, 16'hFFFF);
      write_register(REG_SPARE_HI, 16'h5A5A);
    end
    if ($urandom_range(0, 1) == 1) begin
      write_register(rmi_pkg::REG_ACTION_COUNT, count_data);
      write_register(rmi_pkg::REG_EPSILON, eps_data);
    end else begin
      write_register(rmi_pkg::REG_EPSILON, eps_data);
      write_register(rmi_pkg::REG_ACTION_COUNT, count_data);
    end
    cfg_valid <= 1'b0;
    sb.settings_seen++;
  endtask

  // Stops sending, waits for every outstanding word, then lets any command
  // that returns nothing run to completion.
  task automatic settle();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One random command word. Most are set/accumulate/read traffic on the
  // active actions with small values, so the sums grow into interesting
  // shapes; a minority carries full-range or extreme values, out-of-range
  // indexes, or unused command codes. useful is low for words the unit just
  // drops.
  task automatic send_random(input bit no_gaps, output bit useful);
    logic [2:0]  cmd;
    logic [5:0]  idx;
    logic [31:0] rin;
    logic [31:0] w;
    logic [31:0] draw;
    int          pick;
    int          gap;
    pick = $urandom_range(0, 99);
    if (pick < 30) cmd = rmi_pkg::CMD_SET_INSTANT;
    else if (pick < 48) cmd = rmi_pkg::CMD_ACC_REGRET;
    else if (pick < 62) cmd = rmi_pkg::CMD_ACC_STRATEGY;
    else if (pick < 72) cmd = rmi_pkg::CMD_READ_CURRENT;
    else if (pick < 82) cmd = rmi_pkg::CMD_READ_AVERAGE;
    else if (pick < 94) cmd = rmi_pkg::CMD_READ_REGRET;
    else cmd = ($urandom_range(0, 1) == 1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;

    idx = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, ACTIONS - 1));

    draw = $urandom;
    case ($urandom_range(0, 4))
      0: rin = draw;
      1: begin
        case (draw[1:0])
          2'd0: rin = 32'h7FFFFFFF;
          2'd1: rin = 32'h80000000;
          2'd2: rin = 32'hFFFFFFFF;
          default: rin = '0;
        endcase
      end
      default: rin = {{14{draw[17]}}, draw[17:0]};
    endcase

    draw = $urandom;
    case ($urandom_range(0, 5))
      0: w = draw;
      1: begin
        case (draw[1:0])
          2'd0: w = 32'hFFFFFFFF;
          2'd1: w = 32'h00010000;
          default: w = '0;
        endcase
      end
      default: w = $urandom_range(0, 32'h30000);
    endcase

    // A third of the words follow with no gap even in idling phases.
    if (no_gaps || $urandom_range(0, 2) == 0) gap = 0;
    else gap = $urandom_range(1, 14);

    send_command(cmd, idx, rin, w, gap);
    useful = (cmd != CMD_UNUSED_LO) && (cmd != CMD_UNUSED_HI) &&
             !(cmd == rmi_pkg::CMD_SET_INSTANT && idx >= ACTIONS);
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    int          phase;
    int          useful_items;
    bit          useful;
    bit          no_gaps;
    logic [15:0] count_data;
    logic [15:0] eps_data;

    sb = new();
    sb.clear();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, at reset settings (eight actions, no softening). Reads
    // of the empty store give the uniform share or zero regret sums. Then the
    // instant regrets take the signed extremes, one, minus one, and two
    // out-of-range writes that must be dropped. A full-scale weight pushes two
    // sums into the upper clamp and two into the lower clamp; a zero weight
    // must leave everything alone. Two full-scale strategy accumulations
    // bring two strategy sums to just below saturation. The unused command
    // codes must return nothing. Finally a large negative regret drives a
    // saturated sum back to zero, which must also refresh the cached strategy.
    send_command(rmi_pkg::CMD_READ_CURRENT, 6'd0, 32'd0, 32'd0, 0);
    send_command(rmi_pkg::CMD_READ_AVERAGE, 6'd0, 32'd0, 32'd0, 0);
    send_command(rmi_pkg::CMD_READ_REGRET, 6'd0, 32'd0, 32'd0, 3);
    send_command(rmi_pkg::CMD_SET_INSTANT, 6'd0, 32'h7FFFFFFF, 32'd0, 0);
    send_command(rmi_pkg::CMD_SET_INSTANT, 6'd1, 32'h80000000, 32'd0, 2);
    send_command(rmi_pkg::CMD_SET_INSTANT, 6'd2, 32'h00010000, 32'd0, 0);
    send_command(rmi_pkg::CMD_SET_INSTANT, 6'd7, 32'hFFFFFFFF, 32'd0, 0);
    send_command(rmi_pkg::CMD_SET_INSTANT, 6'd63, 32'h12345678, 32'd0, 0);
    send_command(rmi_pkg::CMD_SET_INSTANT, 6'd8, 32'h00FF00FF, 32'd0, 1);
    send_command(rmi_pkg::CMD_ACC_REGRET, 6'd0, 32'd0, 32'hFFFFFFFF, 0);
    send_command(rmi_pkg::CMD_ACC_REGRET, 6'd0, 32'd0, 32'd0, 0);
    send_command(rmi_pkg::CMD_READ_REGRET, 6'd0, 32'd0, 32'd0, 0);
    send_command(rmi_pkg::CMD_READ_CURRENT, 6'd0, 32'd0, 32'd0, 5);
    send_command(rmi_pkg::CMD_ACC_STRATEGY, 6'd0, 32'd0, 32'hFFFFFFFF, 0);
    send_command(rmi_pkg::CMD_ACC_STRATEGY, 6'd0, 32'd0, 32'hFFFFFFFF, 0);
    send_command(rmi_pkg::CMD_READ_AVERAGE, 6'd0, 32'd0, 32'd0, 0);
    send_command(CMD_UNUSED_LO, 6'd0, 32'd0, 32'd0, 0);
    send_command(CMD_UNUSED_HI, 6'h3F, 32'hFFFFFFFF, 32'hFFFFFFFF, 0);
    send_command(rmi_pkg::CMD_SET_INSTANT, 6'd0, 32'h80000000, 32'd0, 0);
    send_command(rmi_pkg::CMD_ACC_REGRET, 6'd0, 32'd0, 32'h00010000, 0);
    send_command(rmi_pkg::CMD_READ_REGRET, 6'd0, 32'd0, 32'd0, 0);
    send_command(rmi_pkg::CMD_READ_CURRENT, 6'd0, 32'd0, 32'd0, 0);

    // Random part. Each phase waits for the unit to go quiet, which is also
    // where the sender holds back until every expected word is in, then
    // writes both registers. The first phases use the corner settings: a
    // single action with the largest epsilon, a zero count that must act as
    // one, the largest legal count, and an all-ones data word whose count
    // field is far beyond the built size. The first write batch also pokes
    // the two spare register indexes.
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin
          count_data = 16'd1;
          eps_data = 16'hFFFF;
        end
        1: begin
          count_data = 16'd0;
          eps_data = 16'd1;
        end
        2: begin
          count_data = 16'd64;
          eps_data = 16'd0;
        end
        3: begin
          count_data = 16'hFFFF;
          eps_data = 16'h8000;
        end
        default: begin
          count_data = 16'($urandom_range(1, ACTIONS));
          eps_data = ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom);
        end
      endcase
      set_registers(count_data, eps_data, phase == 0);
      no_gaps = ($urandom_range(0, 3) == 0);
      useful_items = 0;
      while (useful_items < ITEMS_PER_PHASE) begin
        send_random(no_gaps, useful);
        if (useful) useful_items++;
      end
    end

    settle();
    $display("Ran %0d commands under %0d register settings and compared %0d result words.",
             sb.commands_seen, sb.settings_seen, sb.words_checked);
    $display("Settings spanned action counts 0, 1, 64 and 127 and epsilon 0 to 65535.");
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: regret_matching_infoset_unit.f
rtl/core/rmi_pkg.sv
rtl/core/rmi_div.sv
rtl/core/rmi_mul.sv
rtl/core/regret_matching_infoset_unit.sv
dv/regret_matching_infoset_unit_tb.sv
